FILE: hw/rtl/tts_pkg.sv
// Shared constants and types for the triangle overlap test.
package tts_pkg;
	localparam int unsigned CoordWidth = 16;
	localparam int unsigned AxisCount  = 11;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_AXIS,
		ST_PROJ,
		ST_DONE
	} ctl_state_t;
endpackage

FILE: hw/rtl/tts_front.sv
// Front end: accepts items, loads the reference, queues test triangles.
module tts_front #(
	parameter int unsigned CW    = tts_pkg::CoordWidth,
	parameter int unsigned DEPTH = tts_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [9*CW-1:0]      in_coords,
	output logic [9*CW-1:0]      ref_coords,
	output logic                 q_valid,
	input  logic                 q_ready,
	output logic [9*CW-1:0]      q_coords
);
	localparam int unsigned AW = $clog2(DEPTH);
	logic [9*CW-1:0] mem_q [DEPTH];
	logic [9*CW-1:0] ref_q;
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            push, pop, full;

	assign full       = (cnt_q == (AW+1)'(DEPTH));
	// a load must wait until queued tests have drained
	assign in_ready   = cmd ? !full : (cnt_q == '0) && q_ready;
	assign push       = in_valid && in_ready && cmd;
	assign q_valid    = (cnt_q != '0);
	assign pop        = q_valid && q_ready;
	assign q_coords   = mem_q[rp_q];
	assign ref_coords = ref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			ref_q <= '0;
		end else begin
			if (in_valid && in_ready && !cmd) ref_q <= in_coords;
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_coords;
	end
endmodule

FILE: hw/rtl/tts_back.sv
// Back end: walks the eleven axes on one shared multiplier set.
module tts_back #(
	parameter int unsigned CW = tts_pkg::CoordWidth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [9*CW-1:0]  ref_coords,
	input  logic             q_valid,
	output logic             q_ready,
	input  logic [9*CW-1:0]  q_coords,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             intersects
);
	localparam int unsigned EW = CW + 1;
	localparam int unsigned XW = 2*CW + 3;
	localparam int unsigned DW = 3*CW + 5;
	localparam int unsigned NA = tts_pkg::AxisCount;
	localparam int unsigned IW = $clog2(NA);

	tts_pkg::ctl_state_t st_q, st_d;
	logic [9*CW-1:0] tst_q;
	logic [IW-1:0]   ax_q;
	logic            ok_q, res_q, ov_q;
	logic signed [XW-1:0] axis_q [3];

	logic signed [CW-1:0] r [9];
	logic signed [CW-1:0] t [9];
	logic signed [EW-1:0] re [3][3];
	logic signed [EW-1:0] te [3][3];
	logic signed [EW-1:0] ea [3];
	logic signed [EW-1:0] eb [3];
	logic signed [XW-1:0] cx [3];
	logic signed [DW-1:0] dr [3];
	logic signed [DW-1:0] dt [3];
	logic signed [DW-1:0] rlo, rhi, tlo, thi;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			r[k] = ref_coords[k*CW +: CW];
			t[k] = tst_q[k*CW +: CW];
		end
		for (int i = 0; i < 3; i++)
			for (int c = 0; c < 3; c++) begin
				re[i][c] = EW'(r[((i+1)%3)*3+c]) - EW'(r[i*3+c]);
				te[i][c] = EW'(t[((i+1)%3)*3+c]) - EW'(t[i*3+c]);
			end
		// face normals first, then each test edge against each reference edge
		unique case (ax_q)
			IW'(0): begin
				ea = re[0];
				eb = re[1];
			end
			IW'(1): begin
				ea = te[0];
				eb = te[1];
			end
			IW'(2): begin
				ea = te[0];
				eb = re[0];
			end
			IW'(3): begin
				ea = te[0];
				eb = re[1];
			end
			IW'(4): begin
				ea = te[0];
				eb = re[2];
			end
			IW'(5): begin
				ea = te[1];
				eb = re[0];
			end
			IW'(6): begin
				ea = te[1];
				eb = re[1];
			end
			IW'(7): begin
				ea = te[1];
				eb = re[2];
			end
			IW'(8): begin
				ea = te[2];
				eb = re[0];
			end
			IW'(9): begin
				ea = te[2];
				eb = re[1];
			end
			IW'(10): begin
				ea = te[2];
				eb = re[2];
			end
			default: begin
				ea = re[0];
				eb = re[1];
			end
		endcase
		cx[0] = XW'(ea[1]) * XW'(eb[2]) - XW'(ea[2]) * XW'(eb[1]);
		cx[1] = XW'(ea[2]) * XW'(eb[0]) - XW'(ea[0]) * XW'(eb[2]);
		cx[2] = XW'(ea[0]) * XW'(eb[1]) - XW'(ea[1]) * XW'(eb[0]);
		for (int v = 0; v < 3; v++) begin
			dr[v] = DW'(axis_q[0]) * DW'(r[v*3]) + DW'(axis_q[1]) * DW'(r[v*3+1])
				+ DW'(axis_q[2]) * DW'(r[v*3+2]);
			dt[v] = DW'(axis_q[0]) * DW'(t[v*3]) + DW'(axis_q[1]) * DW'(t[v*3+1])
				+ DW'(axis_q[2]) * DW'(t[v*3+2]);
		end
		rlo = dr[0]; rhi = dr[0]; tlo = dt[0]; thi = dt[0];
		for (int v = 1; v < 3; v++) begin
			if (dr[v] < rlo) rlo = dr[v];
			if (dr[v] > rhi) rhi = dr[v];
			if (dt[v] < tlo) tlo = dt[v];
			if (dt[v] > thi) thi = dt[v];
		end
		ov_q = (tlo <= rhi) && (rlo <= thi);
	end

	always_comb begin
		st_d    = st_q;
		q_ready = 1'b0;
		unique case (st_q)
			tts_pkg::ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) st_d = tts_pkg::ST_AXIS;
			end
			tts_pkg::ST_AXIS: st_d = tts_pkg::ST_PROJ;
			tts_pkg::ST_PROJ: st_d = (ax_q == IW'(NA-1)) ? tts_pkg::ST_DONE
				: tts_pkg::ST_AXIS;
			tts_pkg::ST_DONE: if (!out_valid || out_ready) st_d = tts_pkg::ST_IDLE;
			default: st_d = tts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= tts_pkg::ST_IDLE;
			ax_q      <= '0;
			ok_q      <= 1'b1;
			out_valid <= 1'b0;
			res_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == tts_pkg::ST_DONE && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
				res_q     <= ok_q;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (st_q)
				tts_pkg::ST_IDLE: begin
					ax_q <= '0;
					ok_q <= 1'b1;
				end
				tts_pkg::ST_PROJ: begin
					ok_q <= ok_q && ov_q;
					ax_q <= ax_q + IW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == tts_pkg::ST_IDLE && q_valid) tst_q <= q_coords;
		if (st_q == tts_pkg::ST_AXIS)
			for (int c = 0; c < 3; c++) axis_q[c] <= cx[c];
	end

	assign intersects = res_q;
endmodule

FILE: hw/rtl/triangle_triangle_sat_test_core.sv
// Triangle-triangle separating-axis overlap test, top level.
// A test item leaves the queue in the idle state when the back end is free; each
// of the eleven axes then takes an axis step (cross product) and a projection step
// (six dot products); a done state registers the result once the old one is taken.
// Tests go through one at a time; loads wait for an empty queue and idle back end.
// Reset clears the reference triangle to all zero and empties queue and output.
module triangle_triangle_sat_test_core #(
	parameter int unsigned COORD_WIDTH = tts_pkg::CoordWidth
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [COORD_WIDTH-1:0] p0_x,
	input  logic [COORD_WIDTH-1:0] p0_y,
	input  logic [COORD_WIDTH-1:0] p0_z,
	input  logic [COORD_WIDTH-1:0] p1_x,
	input  logic [COORD_WIDTH-1:0] p1_y,
	input  logic [COORD_WIDTH-1:0] p1_z,
	input  logic [COORD_WIDTH-1:0] p2_x,
	input  logic [COORD_WIDTH-1:0] p2_y,
	input  logic [COORD_WIDTH-1:0] p2_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   intersects
);
	logic [9*COORD_WIDTH-1:0] coords, ref_coords, q_coords;
	logic q_valid, q_ready;

	assign coords = {p2_z, p2_y, p2_x, p1_z, p1_y, p1_x, p0_z, p0_y, p0_x};

	tts_front #(.CW(COORD_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd,
		.in_coords(coords), .ref_coords, .q_valid, .q_ready, .q_coords
	);

	tts_back #(.CW(COORD_WIDTH)) u_back (
		.clk, .arst_n, .ref_coords, .q_valid, .q_ready, .q_coords,
		.out_valid, .out_ready, .intersects
	);
endmodule
